// ===== rtl/i2cw_pkg.sv =====
// Shared types and constants of the I2C master write engine.
`timescale 1ns / 1ps
`default_nettype none

package i2cw_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int FUNC_W   = 2;
    localparam int DEV_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 2;
    localparam int BITS_W   = 4;

    localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic              WRITE_DIR_BIT = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_BEGIN = 2'd1,
        FUNC_DATA  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_BEGIN,
        CMD_DATA,
        CMD_NOP
    } t_cmd_kind;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_ADDR_BITS,
        SEQ_ADDR_ACK,
        SEQ_REG_BITS,
        SEQ_REG_ACK,
        SEQ_WAIT_DATA,
        SEQ_DATA_BITS,
        SEQ_DATA_ACK,
        SEQ_STOP_OK,
        SEQ_STOP_ADDR,
        SEQ_STOP_DATA
    } t_seq_state;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BUS_BUSY  = 2'd1,
        STATUS_ADDR_NACK = 2'd2,
        STATUS_DATA_NACK = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd_kind         kind;
        logic              sda;
        logic [DEV_W-1:0]  dev_addr;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] data_byte;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic    scl;
        logic    sda;
        logic    busy;
        logic    want;
        logic    done;
        t_status status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/i2cw_if.sv =====
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none

interface i2cw_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [i2cw_pkg::FUNC_W-1:0]     func;
    logic                            sda_in;
    logic [i2cw_pkg::DEV_W-1:0]      dev_addr;
    logic [i2cw_pkg::BYTE_W-1:0]     reg_addr;
    logic [i2cw_pkg::BYTE_W-1:0]     byte_count;
    logic [i2cw_pkg::BYTE_W-1:0]     data_byte;

    modport source (output valid, func, sda_in, dev_addr, reg_addr, byte_count, data_byte,
                    input ready);
    modport sink (input valid, func, sda_in, dev_addr, reg_addr, byte_count, data_byte,
                  output ready);
endinterface

interface i2cw_res_if;
    logic                            valid;
    logic                            ready;
    logic                            scl_out;
    logic                            sda_out;
    logic                            busy_res;
    logic                            want_data;
    logic                            done_res;
    logic [i2cw_pkg::STATUS_W-1:0]   status;

    modport source (output valid, scl_out, sda_out, busy_res, want_data, done_res, status,
                    input ready);
    modport sink (input valid, scl_out, sda_out, busy_res, want_data, done_res, status,
                  output ready);
    modport mon (input valid, ready, scl_out, sda_out, busy_res, want_data, done_res, status);
endinterface

`default_nettype wire

// ===== rtl/i2cw_front.sv =====
// Front end: accept and classify transactions into a short command queue.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_front #(
    parameter int QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    i2cw_cmd_if.sink               i_in,
    input  wire logic              i_pop,
    output i2cw_pkg::t_q_head      o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    i2cw_pkg::t_cmd r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    i2cw_pkg::t_cmd w_cmd;
    logic           w_push;

    assign i_in.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in.valid & i_in.ready;

    // Classify
    always_comb begin
        w_cmd.sda        = i_in.sda_in;
        w_cmd.dev_addr   = i_in.dev_addr;
        w_cmd.reg_addr   = i_in.reg_addr;
        w_cmd.byte_count = i_in.byte_count;
        w_cmd.data_byte  = i_in.data_byte;
        unique case (i2cw_pkg::t_func'(i_in.func))
            i2cw_pkg::FUNC_TICK:  w_cmd.kind = i2cw_pkg::CMD_TICK;
            i2cw_pkg::FUNC_BEGIN: w_cmd.kind = i2cw_pkg::CMD_BEGIN;
            i2cw_pkg::FUNC_DATA:  w_cmd.kind = i2cw_pkg::CMD_DATA;
            default:              w_cmd.kind = i2cw_pkg::CMD_NOP;
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({w_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/i2cw_back.sv =====
// Back end: bus sequencer, configuration register and result register.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    input  wire i2cw_pkg::t_q_head i_head,
    output logic                   o_pop,
    i2cw_res_if.source             o_out
);

    logic                                r_check_data_ack;
    i2cw_pkg::t_seq_state                r_state, n_state;
    logic [i2cw_pkg::PHASE_W-1:0]        r_phase, n_phase;
    logic [i2cw_pkg::BITS_W-1:0]         r_bits_left, n_bits_left;
    logic [i2cw_pkg::BYTE_W-1:0]         r_shift, n_shift;
    logic [i2cw_pkg::BYTE_W-1:0]         r_bytes_left, n_bytes_left;
    logic [i2cw_pkg::BYTE_W-1:0]         r_held_reg, n_held_reg;
    logic                                r_scl, n_scl;
    logic                                r_sda, n_sda;
    logic                                r_out_valid;
    i2cw_pkg::t_result                   r_result, n_result;

    logic                                w_done;
    i2cw_pkg::t_status                   w_status;
    logic [i2cw_pkg::BITS_W-1:0]         w_bits_dec;
    i2cw_pkg::t_seq_state                w_after_ack;

    assign o_pop      = i_head.valid & (~r_out_valid | o_out.ready);
    assign w_bits_dec = r_bits_left - 1'b1;
    assign w_after_ack = (r_bytes_left == '0) ? i2cw_pkg::SEQ_STOP_OK
                                              : i2cw_pkg::SEQ_WAIT_DATA;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_bits_left  = r_bits_left;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_held_reg   = r_held_reg;
        n_scl        = r_scl;
        n_sda        = r_sda;
        w_done       = 1'b0;
        w_status     = i2cw_pkg::STATUS_OK;
        unique case (i_head.cmd.kind)
            i2cw_pkg::CMD_TICK: begin
                unique case (r_state)
                    i2cw_pkg::SEQ_START: begin
                        if (r_phase == 2'd0) begin
                            n_sda = 1'b1;
                            n_scl = 1'b1;
                            if (!i_head.cmd.sda) begin
                                n_state  = i2cw_pkg::SEQ_IDLE;
                                w_done   = 1'b1;
                                w_status = i2cw_pkg::STATUS_BUS_BUSY;
                            end else begin
                                n_phase = 2'd1;
                            end
                        end else if (r_phase == 2'd1) begin
                            n_sda = 1'b0;
                            if (i_head.cmd.sda) begin
                                n_sda    = 1'b1;
                                n_scl    = 1'b1;
                                n_state  = i2cw_pkg::SEQ_IDLE;
                                n_phase  = 2'd0;
                                w_done   = 1'b1;
                                w_status = i2cw_pkg::STATUS_BUS_BUSY;
                            end else begin
                                n_phase = 2'd2;
                            end
                        end else begin
                            n_sda       = 1'b0;
                            n_phase     = 2'd0;
                            n_bits_left = i2cw_pkg::BITS_PER_BYTE;
                            n_state     = i2cw_pkg::SEQ_ADDR_BITS;
                        end
                    end
                    i2cw_pkg::SEQ_ADDR_BITS, i2cw_pkg::SEQ_REG_BITS,
                    i2cw_pkg::SEQ_DATA_BITS: begin
                        if (r_phase == 2'd0) begin
                            n_scl   = 1'b0;
                            n_phase = 2'd1;
                        end else if (r_phase == 2'd1) begin
                            n_sda   = r_shift[i2cw_pkg::BYTE_W-1];
                            n_shift = {r_shift[i2cw_pkg::BYTE_W-2:0], 1'b0};
                            n_phase = 2'd2;
                        end else begin
                            n_scl       = 1'b1;
                            n_phase     = 2'd0;
                            n_bits_left = w_bits_dec;
                            if (w_bits_dec == '0) begin
                                priority case (r_state)
                                    i2cw_pkg::SEQ_ADDR_BITS: n_state = i2cw_pkg::SEQ_ADDR_ACK;
                                    i2cw_pkg::SEQ_REG_BITS:  n_state = i2cw_pkg::SEQ_REG_ACK;
                                    default:                 n_state = i2cw_pkg::SEQ_DATA_ACK;
                                endcase
                            end
                        end
                    end
                    i2cw_pkg::SEQ_ADDR_ACK, i2cw_pkg::SEQ_REG_ACK,
                    i2cw_pkg::SEQ_DATA_ACK: begin
                        if (r_phase == 2'd0) begin
                            n_scl   = 1'b0;
                            n_phase = 2'd1;
                        end else if (r_phase == 2'd1) begin
                            n_sda   = 1'b1;
                            n_phase = 2'd2;
                        end else begin
                            n_scl   = 1'b1;
                            n_phase = 2'd0;
                            priority case (r_state)
                                i2cw_pkg::SEQ_ADDR_ACK: begin
                                    if (!i_head.cmd.sda) begin
                                        n_shift     = r_held_reg;
                                        n_bits_left = i2cw_pkg::BITS_PER_BYTE;
                                        n_state     = i2cw_pkg::SEQ_REG_BITS;
                                    end else begin
                                        n_state = i2cw_pkg::SEQ_STOP_ADDR;
                                    end
                                end
                                i2cw_pkg::SEQ_REG_ACK: begin
                                    n_state = w_after_ack;
                                end
                                default: begin
                                    if (i_head.cmd.sda && r_check_data_ack) begin
                                        n_state = i2cw_pkg::SEQ_STOP_DATA;
                                    end else begin
                                        n_state = w_after_ack;
                                    end
                                end
                            endcase
                        end
                    end
                    i2cw_pkg::SEQ_STOP_OK, i2cw_pkg::SEQ_STOP_ADDR,
                    i2cw_pkg::SEQ_STOP_DATA: begin
                        unique case (r_phase)
                            2'd0: begin
                                n_scl   = 1'b0;
                                n_phase = 2'd1;
                            end
                            2'd1: begin
                                n_sda   = 1'b0;
                                n_phase = 2'd2;
                            end
                            2'd2: begin
                                n_scl   = 1'b1;
                                n_phase = 2'd3;
                            end
                            default: begin
                                n_sda   = 1'b1;
                                n_phase = 2'd0;
                                w_done  = 1'b1;
                                n_state = i2cw_pkg::SEQ_IDLE;
                                priority case (r_state)
                                    i2cw_pkg::SEQ_STOP_ADDR:
                                        w_status = i2cw_pkg::STATUS_ADDR_NACK;
                                    i2cw_pkg::SEQ_STOP_DATA:
                                        w_status = i2cw_pkg::STATUS_DATA_NACK;
                                    default:
                                        w_status = i2cw_pkg::STATUS_OK;
                                endcase
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
            i2cw_pkg::CMD_BEGIN: begin
                if (r_state == i2cw_pkg::SEQ_IDLE) begin
                    n_shift      = {i_head.cmd.dev_addr, i2cw_pkg::WRITE_DIR_BIT};
                    n_held_reg   = i_head.cmd.reg_addr;
                    n_bytes_left = i_head.cmd.byte_count;
                    n_bits_left  = '0;
                    n_phase      = 2'd0;
                    n_state      = i2cw_pkg::SEQ_START;
                end
            end
            i2cw_pkg::CMD_DATA: begin
                if (r_state == i2cw_pkg::SEQ_WAIT_DATA) begin
                    n_shift      = i_head.cmd.data_byte;
                    n_bits_left  = i2cw_pkg::BITS_PER_BYTE;
                    n_phase      = 2'd0;
                    n_bytes_left = r_bytes_left - 1'b1;
                    n_state      = i2cw_pkg::SEQ_DATA_BITS;
                end
            end
            default: begin
            end
        endcase

        n_result.scl    = n_scl;
        n_result.sda    = n_sda;
        n_result.busy   = (n_state != i2cw_pkg::SEQ_IDLE);
        n_result.want   = (n_state == i2cw_pkg::SEQ_WAIT_DATA);
        n_result.done   = w_done;
        n_result.status = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_data_ack <= 1'b1;
            r_state          <= i2cw_pkg::SEQ_IDLE;
            r_phase          <= '0;
            r_bits_left      <= '0;
            r_shift          <= '0;
            r_bytes_left     <= '0;
            r_held_reg       <= '0;
            r_scl            <= 1'b1;
            r_sda            <= 1'b1;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_check_data_ack <= i_cfg_data;
            end
            if (o_pop) begin
                r_state      <= n_state;
                r_phase      <= n_phase;
                r_bits_left  <= n_bits_left;
                r_shift      <= n_shift;
                r_bytes_left <= n_bytes_left;
                r_held_reg   <= n_held_reg;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl_out   = r_result.scl;
    assign o_out.sda_out   = r_result.sda;
    assign o_out.busy_res  = r_result.busy;
    assign o_out.want_data = r_result.want;
    assign o_out.done_res  = r_result.done;
    assign o_out.status    = r_result.status;

endmodule

`default_nettype wire

// ===== rtl/i2c_master_write_engine.sv =====
// Top level of the I2C master register-write engine.
//
// Usage: commands enter on i_in (func 0 tick one bus phase with the sampled
// SDA level, func 1 begin a register write, func 2 supply the next data
// byte, func 3 no operation). Every accepted command yields exactly one
// result on o_out: SCL/SDA drive (1 released), busy, data request, done
// and a status code. i_cfg_we/i_cfg_data write check_data_ack; write it
// only while idle, the block itself does not enforce this. A command is
// queued, then popped into the back end, which registers its result.
// Throughput: one command per cycle unless o_out stalls, set by the single
// sequencer state update in the back end; the command queue (QUEUE_DEPTH
// entries) and result register let the front accept while a result waits.
// Reset: queue empty, sequencer idle, both lines released, no result
// pending, check_data_ack set to 1.
// Stall: a pending result holds and the back end stops while o_out.ready
// is low; i_in.ready drops once the queue is full and returns as it drains.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_write_engine #(
    parameter int QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    i2cw_cmd_if.sink    i_in,
    i2cw_res_if.source  o_out,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_data
);

    i2cw_pkg::t_q_head w_head;
    logic              w_pop;

    i2cw_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    i2cw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/i2cw_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          i_ready,
    input  wire logic                          i_scl,
    input  wire logic                          i_sda,
    input  wire logic                          i_busy,
    input  wire logic                          i_want,
    input  wire logic                          i_done,
    input  wire logic [i2cw_pkg::STATUS_W-1:0] i_status
);

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_scl)
            && $stable(i_sda) && $stable(i_done) && $stable(i_status)))
        else $error("result changed while stalled");

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_done) |-> (i_status == i2cw_pkg::STATUS_OK))
        else $error("nonzero status without done");

    a_want_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_want) |-> i_busy)
        else $error("data request while not busy");

    a_done_releases_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_done) |-> (!i_busy && i_scl && i_sda))
        else $error("bus not released at done");

endmodule

bind i2c_master_write_engine i2cw_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_scl    (o_out.scl_out),
    .i_sda    (o_out.sda_out),
    .i_busy   (o_out.busy_res),
    .i_want   (o_out.want_data),
    .i_done   (o_out.done_res),
    .i_status (o_out.status)
);

`default_nettype wire

// ===== verif/i2c_master_write_engine_tb.sv =====
// Self-checking testbench for the I2C master register-write engine.
`timescale 1ns / 1ps

typedef enum logic [1:0] {
    ACK_BUSY,
    ACK_SEEN,
    ACK_MISSING
} t_ack_step;

class write_scoreboard;
    i2cw_pkg::t_seq_state        seq;
    logic [1:0]                  phase;
    logic [i2cw_pkg::BITS_W-1:0] bits_left;
    logic [i2cw_pkg::BYTE_W-1:0] shift_reg;
    logic [i2cw_pkg::BYTE_W-1:0] bytes_left;
    logic [i2cw_pkg::BYTE_W-1:0] held_reg;
    logic                        scl_lvl;
    logic                        sda_lvl;
    logic                        check_ack;
    i2cw_pkg::t_result           expected_q[$];
    int                          mismatches;
    int                          results_seen;
    int                          status_seen[4];

    function new();
        check_ack    = 1'b1;
        seq          = i2cw_pkg::SEQ_IDLE;
        phase        = '0;
        bits_left    = '0;
        shift_reg    = '0;
        bytes_left   = '0;
        held_reg     = '0;
        scl_lvl      = 1'b1;
        sda_lvl      = 1'b1;
        mismatches   = 0;
        results_seen = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit shift_bit_phase();
        case (phase)
            2'd0: begin
                scl_lvl = 1'b0;
                phase   = 2'd1;
            end
            2'd1: begin
                sda_lvl   = shift_reg[i2cw_pkg::BYTE_W-1];
                shift_reg = shift_reg << 1;
                phase     = 2'd2;
            end
            default: begin
                scl_lvl   = 1'b1;
                phase     = 2'd0;
                bits_left = bits_left - 1'b1;
                return bits_left == '0;
            end
        endcase
        return 1'b0;
    endfunction

    function t_ack_step ack_bit_phase(logic line);
        case (phase)
            2'd0: begin
                scl_lvl = 1'b0;
                phase   = 2'd1;
            end
            2'd1: begin
                sda_lvl = 1'b1;
                phase   = 2'd2;
            end
            default: begin
                scl_lvl = 1'b1;
                phase   = 2'd0;
                return line ? ACK_MISSING : ACK_SEEN;
            end
        endcase
        return ACK_BUSY;
    endfunction

    function void after_ack();
        phase = 2'd0;
        if (bytes_left == '0) seq = i2cw_pkg::SEQ_STOP_OK;
        else seq = i2cw_pkg::SEQ_WAIT_DATA;
    endfunction

    function void bus_phase(logic line, output logic done, output i2cw_pkg::t_status st);
        t_ack_step outcome;
        done = 1'b0;
        st   = i2cw_pkg::STATUS_OK;
        case (seq)
            i2cw_pkg::SEQ_START: begin
                if (phase == 2'd0) begin
                    sda_lvl = 1'b1;
                    scl_lvl = 1'b1;
                    if (!line) begin
                        seq  = i2cw_pkg::SEQ_IDLE;
                        done = 1'b1;
                        st   = i2cw_pkg::STATUS_BUS_BUSY;
                    end else begin
                        phase = 2'd1;
                    end
                end else if (phase == 2'd1) begin
                    sda_lvl = 1'b0;
                    if (line) begin
                        sda_lvl = 1'b1;
                        scl_lvl = 1'b1;
                        seq     = i2cw_pkg::SEQ_IDLE;
                        phase   = 2'd0;
                        done    = 1'b1;
                        st      = i2cw_pkg::STATUS_BUS_BUSY;
                    end else begin
                        phase = 2'd2;
                    end
                end else begin
                    sda_lvl   = 1'b0;
                    phase     = 2'd0;
                    bits_left = i2cw_pkg::BITS_PER_BYTE;
                    seq       = i2cw_pkg::SEQ_ADDR_BITS;
                end
            end
            i2cw_pkg::SEQ_ADDR_BITS: if (shift_bit_phase()) seq = i2cw_pkg::SEQ_ADDR_ACK;
            i2cw_pkg::SEQ_ADDR_ACK: begin
                outcome = ack_bit_phase(line);
                if (outcome == ACK_SEEN) begin
                    shift_reg = held_reg;
                    bits_left = i2cw_pkg::BITS_PER_BYTE;
                    seq       = i2cw_pkg::SEQ_REG_BITS;
                end else if (outcome == ACK_MISSING) begin
                    seq = i2cw_pkg::SEQ_STOP_ADDR;
                end
            end
            i2cw_pkg::SEQ_REG_BITS: if (shift_bit_phase()) seq = i2cw_pkg::SEQ_REG_ACK;
            i2cw_pkg::SEQ_REG_ACK: if (ack_bit_phase(line) != ACK_BUSY) after_ack();
            i2cw_pkg::SEQ_DATA_BITS: if (shift_bit_phase()) seq = i2cw_pkg::SEQ_DATA_ACK;
            i2cw_pkg::SEQ_DATA_ACK: begin
                outcome = ack_bit_phase(line);
                if (outcome == ACK_MISSING && check_ack) seq = i2cw_pkg::SEQ_STOP_DATA;
                else if (outcome != ACK_BUSY) after_ack();
            end
            i2cw_pkg::SEQ_STOP_OK, i2cw_pkg::SEQ_STOP_ADDR, i2cw_pkg::SEQ_STOP_DATA: begin
                case (phase)
                    2'd0: begin
                        scl_lvl = 1'b0;
                        phase   = 2'd1;
                    end
                    2'd1: begin
                        sda_lvl = 1'b0;
                        phase   = 2'd2;
                    end
                    2'd2: begin
                        scl_lvl = 1'b1;
                        phase   = 2'd3;
                    end
                    default: begin
                        sda_lvl = 1'b1;
                        phase   = 2'd0;
                        done    = 1'b1;
                        if (seq == i2cw_pkg::SEQ_STOP_ADDR) st = i2cw_pkg::STATUS_ADDR_NACK;
                        else if (seq == i2cw_pkg::SEQ_STOP_DATA) st = i2cw_pkg::STATUS_DATA_NACK;
                        else st = i2cw_pkg::STATUS_OK;
                        seq = i2cw_pkg::SEQ_IDLE;
                    end
                endcase
            end
            default: ;
        endcase
    endfunction

    function bit note_cmd(i2cw_pkg::t_func func, logic line,
                          logic [i2cw_pkg::DEV_W-1:0] dev,
                          logic [i2cw_pkg::BYTE_W-1:0] ra,
                          logic [i2cw_pkg::BYTE_W-1:0] cnt,
                          logic [i2cw_pkg::BYTE_W-1:0] dat);
        bit                effective;
        logic              done;
        i2cw_pkg::t_status st;
        i2cw_pkg::t_result want;
        effective = 1'b0;
        done      = 1'b0;
        st        = i2cw_pkg::STATUS_OK;
        case (func)
            i2cw_pkg::FUNC_TICK: begin
                effective = seq != i2cw_pkg::SEQ_IDLE && seq != i2cw_pkg::SEQ_WAIT_DATA;
                bus_phase(line, done, st);
            end
            i2cw_pkg::FUNC_BEGIN: if (seq == i2cw_pkg::SEQ_IDLE) begin
                effective  = 1'b1;
                shift_reg  = {dev, i2cw_pkg::WRITE_DIR_BIT};
                held_reg   = ra;
                bytes_left = cnt;
                bits_left  = '0;
                phase      = 2'd0;
                seq        = i2cw_pkg::SEQ_START;
            end
            i2cw_pkg::FUNC_DATA: if (seq == i2cw_pkg::SEQ_WAIT_DATA) begin
                effective  = 1'b1;
                shift_reg  = dat;
                bits_left  = i2cw_pkg::BITS_PER_BYTE;
                phase      = 2'd0;
                bytes_left = bytes_left - 1'b1;
                seq        = i2cw_pkg::SEQ_DATA_BITS;
            end
            default: ;
        endcase
        want.scl    = scl_lvl;
        want.sda    = sda_lvl;
        want.busy   = seq != i2cw_pkg::SEQ_IDLE;
        want.want   = seq == i2cw_pkg::SEQ_WAIT_DATA;
        want.done   = done;
        want.status = st;
        expected_q.push_back(want);
        return effective;
    endfunction

    function void check_field(string name, logic [1:0] want, logic [1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(i2cw_pkg::t_result got);
        i2cw_pkg::t_result want;
        results_seen++;
        if (got.done === 1'b1) status_seen[got.status]++;
        if (expected_q.size() == 0) begin
            $error("result arrived with no command waiting for it");
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        check_field("scl_out", want.scl, got.scl);
        check_field("sda_out", want.sda, got.sda);
        check_field("busy_res", want.busy, got.busy);
        check_field("want_data", want.want, got.want);
        check_field("done_res", want.done, got.done);
        check_field("status", want.status, got.status);
    endfunction
endclass

module i2c_master_write_engine_tb;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int HOLD_AFTER       = 300;
    localparam int HOLD_CYCLES      = 250;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_LIMIT      = 20000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;
    int   commands_sent;
    int   effective_sent;
    int   burst_left;

    write_scoreboard sb = new();

    i2cw_cmd_if cmd_if ();
    i2cw_res_if res_if ();

    i2c_master_write_engine u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (cmd_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_cmd(i2cw_pkg::t_func func, logic line,
                            logic [i2cw_pkg::DEV_W-1:0] dev,
                            logic [i2cw_pkg::BYTE_W-1:0] ra,
                            logic [i2cw_pkg::BYTE_W-1:0] cnt,
                            logic [i2cw_pkg::BYTE_W-1:0] dat);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_if.valid      <= 1'b1;
        cmd_if.func       <= func;
        cmd_if.sda_in     <= line;
        cmd_if.dev_addr   <= dev;
        cmd_if.reg_addr   <= ra;
        cmd_if.byte_count <= cnt;
        cmd_if.data_byte  <= dat;
        do @(posedge clk); while (cmd_if.ready !== 1'b1);
        commands_sent++;
        if (sb.note_cmd(func, line, dev, ra, cnt, dat)) effective_sent++;
        @(negedge clk);
    endtask

    task automatic send_guided();
        i2cw_pkg::t_func             func;
        logic                        line;
        logic [i2cw_pkg::DEV_W-1:0]  dev;
        logic [i2cw_pkg::BYTE_W-1:0] ra;
        logic [i2cw_pkg::BYTE_W-1:0] cnt;
        logic [i2cw_pkg::BYTE_W-1:0] dat;
        int                          roll;
        func = i2cw_pkg::FUNC_TICK;
        line = 1'($urandom);
        dev  = i2cw_pkg::DEV_W'($urandom);
        ra   = i2cw_pkg::BYTE_W'($urandom);
        cnt  = i2cw_pkg::BYTE_W'($urandom);
        dat  = i2cw_pkg::BYTE_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            func = i2cw_pkg::t_func'($urandom_range(0, 3));
        end else begin
            case (sb.seq)
                i2cw_pkg::SEQ_IDLE: begin
                    func = i2cw_pkg::FUNC_BEGIN;
                    case ($urandom_range(0, 7))
                        0: dev = '0;
                        1: dev = '1;
                        default: ;
                    endcase
                    if (roll < 14) cnt = '0;
                    else if (roll < 17 && sb.check_ack) cnt = '1;
                    else cnt = i2cw_pkg::BYTE_W'($urandom_range(1, 4));
                end
                i2cw_pkg::SEQ_START: begin
                    if (sb.phase == 2'd0) line = roll >= 8;
                    else if (sb.phase == 2'd1) line = roll < 8;
                end
                i2cw_pkg::SEQ_ADDR_ACK: if (sb.phase == 2'd2) line = roll < 14;
                i2cw_pkg::SEQ_DATA_ACK: if (sb.phase == 2'd2) line = roll < 16;
                i2cw_pkg::SEQ_WAIT_DATA: begin
                    if (roll >= 12) func = i2cw_pkg::FUNC_DATA;
                    case ($urandom_range(0, 7))
                        0: dat = '0;
                        1: dat = '1;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        send_cmd(func, line, dev, ra, cnt, dat);
    endtask

    task automatic wait_results_drained();
        int cycles;
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        cycles     = 0;
        while (sb.expected_q.size() != 0 && cycles < DRAIN_LIMIT) begin
            @(negedge clk);
            cycles++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_check_ack(logic value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        sb.check_ack = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk) begin : result_monitor
        i2cw_pkg::t_result seen;
        if (rst_n && res_if.valid && res_if.ready) begin
            seen.scl    = res_if.scl_out;
            seen.sda    = res_if.sda_out;
            seen.busy   = res_if.busy_res;
            seen.want   = res_if.want_data;
            seen.done   = res_if.done_res;
            seen.status = i2cw_pkg::t_status'(res_if.status);
            sb.check_result(seen);
        end
    end

    initial begin
        int  mode;
        bit  hold_done;
        res_if.ready = 1'b0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(8, 64)) begin
                @(negedge clk);
                if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    res_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= 1'($urandom_range(0, 1));
                    2: res_if.ready <= $urandom_range(0, 3) == 0;
                    default: res_if.ready <= $urandom_range(0, 3) != 0;
                endcase
            end
        end
    end

    initial begin
        #2_000_000;
        $error("run did not finish in time");
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int target;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.func       = i2cw_pkg::FUNC_NONE;
        cmd_if.sda_in     = 1'b1;
        cmd_if.dev_addr   = '0;
        cmd_if.reg_addr   = '0;
        cmd_if.byte_count = '0;
        cmd_if.data_byte  = '0;
        commands_sent     = 0;
        effective_sent    = 0;
        burst_left        = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_check_ack(1'b1);

        send_cmd(i2cw_pkg::FUNC_NONE, 1'b1, '1, '1, '1, '1);
        send_cmd(i2cw_pkg::FUNC_DATA, 1'b0, '0, '0, '0, '1);
        send_cmd(i2cw_pkg::FUNC_TICK, 1'b0, '0, '0, '0, '0);
        send_cmd(i2cw_pkg::FUNC_BEGIN, 1'b1, '0, '0, '0, '0);
        send_cmd(i2cw_pkg::FUNC_TICK, 1'b0, '0, '0, '0, '0);
        send_cmd(i2cw_pkg::FUNC_BEGIN, 1'b0, '1, '1, '1, '1);
        send_cmd(i2cw_pkg::FUNC_TICK, 1'b1, '0, '0, '0, '0);
        send_cmd(i2cw_pkg::FUNC_TICK, 1'b1, '0, '0, '0, '0);
        send_cmd(i2cw_pkg::FUNC_BEGIN, 1'b1, 7'h2A, 8'h55, 8'd1, '0);
        send_cmd(i2cw_pkg::FUNC_BEGIN, 1'b0, 7'h55, 8'hAA, 8'd7, '0);
        send_cmd(i2cw_pkg::FUNC_DATA, 1'b1, '0, '0, '0, 8'hA5);
        send_cmd(i2cw_pkg::FUNC_NONE, 1'b0, '1, '1, '1, '1);

        for (int p = 0; p < 4; p++) begin
            if (p > 0) begin
                wait_results_drained();
                write_check_ack(p % 2 == 0);
            end
            target = effective_sent + RANDOM_PER_PHASE;
            while (effective_sent < target || sb.seq != i2cw_pkg::SEQ_IDLE) send_guided();
        end
        wait_results_drained();

        if (sb.expected_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.mismatches++;
        end
        $display("Run covered %0d commands (%0d advancing the engine) and %0d results.",
                 commands_sent, effective_sent, sb.results_seen);
        $display("Finished transfers: %0d ok, %0d bus busy, %0d address nack, %0d data nack.",
                 sb.status_seen[i2cw_pkg::STATUS_OK],
                 sb.status_seen[i2cw_pkg::STATUS_BUS_BUSY],
                 sb.status_seen[i2cw_pkg::STATUS_ADDR_NACK],
                 sb.status_seen[i2cw_pkg::STATUS_DATA_NACK]);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
